@@ rtl/dqdel_pkg.sv @@
// ----------------------------------------------------------------------------
// dqdel_pkg
// Shared sizes, request and status codes, and slot arithmetic for the
// deque with delete-by-value.
// ----------------------------------------------------------------------------
package dqdel_pkg;

    // Geometry
    localparam int DEPTH      = 16;
    localparam int ITEM_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Port field widths
    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LENGTH_W = 5;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [ITEM_WIDTH-1:0] t_item;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Slot of (head + offset) modulo DEPTH, offset below DEPTH
    function automatic t_idx slot_add(input t_idx head, input t_idx offset);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= (IDX_W + 1)'(DEPTH)) begin
            sum = sum - (IDX_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Slot one before the given one, modulo DEPTH
    function automatic t_idx slot_dec(input t_idx slot);
        t_idx res;
        if (slot == '0) begin
            res = IDX_W'(DEPTH - 1);
        end else begin
            res = slot - 1'b1;
        end
        return res;
    endfunction

endpackage

@@ rtl/dqdel_ram.sv @@
// ----------------------------------------------------------------------------
// dqdel_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module dqdel_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

@@ rtl/deque_with_delete_by_value_unit.sv @@
// ----------------------------------------------------------------------------
// deque_with_delete_by_value_unit
// Bounded deque: append at tail, insert at head, pop head, delete first
// matching value with gap closing. Entries live in one RAM.
// ----------------------------------------------------------------------------
// Sequence: append/insert/failures go straight to the finish state, pop
// reads the head entry first, delete walks with one RAM read per held
// entry (the shift rides the walk). One request at a time; the next is
// taken once the previous result has reached the output register.
// Reset: synchronous active low; clears head, count and handshake state.
// The entry RAM is not cleared; only held entries are ever read.
// ----------------------------------------------------------------------------
module deque_with_delete_by_value_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [dqdel_pkg::KIND_W-1:0]   i_kind,
    input  logic [dqdel_pkg::VALUE_W-1:0]  i_item_value,
    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [dqdel_pkg::STATUS_W-1:0] o_status,
    output logic [dqdel_pkg::VALUE_W-1:0]  o_popped_item,
    output logic [dqdel_pkg::LENGTH_W-1:0] o_length
);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]                     r_state,  n_state;
    dqdel_pkg::t_idx                r_head,   n_head;
    dqdel_pkg::t_cnt                r_count,  n_count;
    dqdel_pkg::t_item               r_value,  n_value;
    logic [dqdel_pkg::STATUS_W-1:0] r_status, n_status;
    dqdel_pkg::t_item               r_popped, n_popped;
    // Delete walk: next offset to read, offset of data returning, match seen
    dqdel_pkg::t_cnt                r_rd_off, n_rd_off;
    logic                           r_dv,     n_dv;
    dqdel_pkg::t_idx                r_dv_off, n_dv_off;
    logic                           r_found,  n_found;
    // Output register
    logic                           r_out_valid, n_out_valid;
    logic [dqdel_pkg::STATUS_W-1:0] r_out_status;
    logic [dqdel_pkg::VALUE_W-1:0]  r_out_popped;
    logic [dqdel_pkg::LENGTH_W-1:0] r_out_length;

    // RAM port signals
    logic             ram_wr_en;
    dqdel_pkg::t_idx  ram_wr_addr;
    dqdel_pkg::t_item ram_wr_data;
    logic             ram_rd_en;
    dqdel_pkg::t_idx  ram_rd_addr;
    dqdel_pkg::t_item ram_rd_data;

    logic             in_beat;
    logic             out_load;
    dqdel_pkg::t_item in_value;
    logic             is_full;
    logic             is_empty;
    logic             match;
    logic             last_data;

    dqdel_ram #(
        .WIDTH (dqdel_pkg::ITEM_WIDTH),
        .DEPTH (dqdel_pkg::DEPTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_beat    = i_in_valid && o_in_ready;
    assign in_value   = i_item_value[dqdel_pkg::ITEM_WIDTH-1:0];
    assign is_full    = (r_count == dqdel_pkg::CNT_W'(dqdel_pkg::DEPTH));
    assign is_empty   = (r_count == '0);
    assign match      = (ram_rd_data == r_value);
    assign last_data  = r_dv && ((dqdel_pkg::CNT_W'(r_dv_off) + 1'b1) == r_count);
    assign out_load   = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    // Sequencer and RAM access
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_value     = r_value;
        n_status    = r_status;
        n_popped    = r_popped;
        n_rd_off    = r_rd_off;
        n_dv        = 1'b0;
        n_dv_off    = r_dv_off;
        n_found     = r_found;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_head;
        ram_wr_data = in_value;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_value  = in_value;
                    n_status = dqdel_pkg::ST_OK;
                    n_popped = '0;
                    n_found  = 1'b0;
                    n_state  = S_FIN;
                    unique case (i_kind)
                        dqdel_pkg::KIND_APPEND: begin
                            if (is_full) begin
                                n_status = dqdel_pkg::ST_FULL;
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = dqdel_pkg::slot_add(
                                    r_head, r_count[dqdel_pkg::IDX_W-1:0]);
                                n_count     = r_count + 1'b1;
                            end
                        end
                        dqdel_pkg::KIND_INSERT: begin
                            if (is_full) begin
                                n_status = dqdel_pkg::ST_FULL;
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = dqdel_pkg::slot_dec(r_head);
                                n_head      = dqdel_pkg::slot_dec(r_head);
                                n_count     = r_count + 1'b1;
                            end
                        end
                        dqdel_pkg::KIND_POP: begin
                            if (is_empty) begin
                                n_status = dqdel_pkg::ST_EMPTY;
                            end else begin
                                ram_rd_en = 1'b1;
                                n_head    = dqdel_pkg::slot_add(r_head,
                                                dqdel_pkg::IDX_W'(1));
                                n_count   = r_count - 1'b1;
                                n_state   = S_POP;
                            end
                        end
                        default: begin
                            // Delete: start walk at the head entry
                            if (is_empty) begin
                                n_status = dqdel_pkg::ST_NOT_FOUND;
                            end else begin
                                ram_rd_en = 1'b1;
                                n_rd_off  = dqdel_pkg::CNT_W'(1);
                                n_dv      = 1'b1;
                                n_dv_off  = '0;
                                n_state   = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_POP: begin
                n_popped = ram_rd_data;
                n_state  = S_FIN;
            end
            S_WALK: begin
                // Issue the next read while entries remain
                if (r_rd_off < r_count) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = dqdel_pkg::slot_add(r_head,
                                      r_rd_off[dqdel_pkg::IDX_W-1:0]);
                    n_rd_off    = r_rd_off + 1'b1;
                    n_dv        = 1'b1;
                    n_dv_off    = r_rd_off[dqdel_pkg::IDX_W-1:0];
                end
                // Returning entry: shift it down once a match lies behind it
                if (r_dv) begin
                    if (r_found) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = dqdel_pkg::slot_add(r_head, r_dv_off - 1'b1);
                        ram_wr_data = ram_rd_data;
                    end else if (match) begin
                        n_found = 1'b1;
                    end
                end
                if (last_data) begin
                    n_state = S_FIN;
                    if (r_found || match) begin
                        n_count = r_count - 1'b1;
                    end else begin
                        n_status = dqdel_pkg::ST_NOT_FOUND;
                    end
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_rd_off    <= '0;
            r_dv        <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_rd_off    <= n_rd_off;
            r_dv        <= n_dv;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_status <= n_status;
        r_popped <= n_popped;
        r_dv_off <= n_dv_off;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_popped <= dqdel_pkg::VALUE_W'(r_popped);
            r_out_length <= dqdel_pkg::LENGTH_W'(r_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_popped_item = r_out_popped;
    assign o_length      = r_out_length;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the deque with delete-by-value. A driver sends
// request beats from a pending list, an in-bench deque model predicts each
// result at acceptance, and a monitor compares every result beat field by
// field. Runs a directed opening, then biased random fill/drain traffic
// under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_ITEMS = 500;
    localparam int MAX_BEATS    = 4096;

    // Expected result of one request
    typedef struct packed {
        logic [dqdel_pkg::STATUS_W-1:0] status;
        logic [dqdel_pkg::VALUE_W-1:0]  popped;
        logic [dqdel_pkg::LENGTH_W-1:0] length;
    } t_deque_result;

    // One pending request beat
    typedef struct packed {
        logic [dqdel_pkg::KIND_W-1:0]  kind;
        logic [dqdel_pkg::VALUE_W-1:0] value;
    } t_deque_request;

    // Traffic patterns, in run order
    typedef enum int {
        PH_STEADY,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH_IDLE,
        PH_TAIL
    } t_idle_phase;

    // DUT signals
    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           i_in_valid   = 1'b0;
    logic                           o_in_ready;
    logic [dqdel_pkg::KIND_W-1:0]   i_kind       = dqdel_pkg::KIND_APPEND;
    logic [dqdel_pkg::VALUE_W-1:0]  i_item_value = '0;
    logic                           o_out_valid;
    logic                           i_out_ready  = 1'b0;
    logic [dqdel_pkg::STATUS_W-1:0] o_status;
    logic [dqdel_pkg::VALUE_W-1:0]  o_popped_item;
    logic [dqdel_pkg::LENGTH_W-1:0] o_length;

    // Model state of the deque
    dqdel_pkg::t_item slot_values [dqdel_pkg::DEPTH];
    dqdel_pkg::t_idx  head_slot   = '0;
    int               held_count  = 0;

    // Bench bookkeeping
    t_deque_request pending_requests[$];
    t_deque_result  expected_results [MAX_BEATS];
    int             accepted_beats  = 0;
    int             received_beats  = 0;
    int             launched_beats  = 0;
    int             total_requests  = 0;
    int             mismatch_count  = 0;
    t_idle_phase    drive_phase     = PH_STEADY;

    deque_with_delete_by_value_unit dut (.*);

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one request to the model deque and return its result
    function automatic t_deque_result apply_request(
        input logic [dqdel_pkg::KIND_W-1:0]  kind,
        input logic [dqdel_pkg::VALUE_W-1:0] value);
        t_deque_result    res;
        dqdel_pkg::t_item item;
        int               hit;
        res.status = dqdel_pkg::ST_OK;
        res.popped = '0;
        item       = dqdel_pkg::t_item'(value);
        hit        = -1;
        case (kind)
            dqdel_pkg::KIND_APPEND: begin
                if (held_count >= dqdel_pkg::DEPTH) begin
                    res.status = dqdel_pkg::ST_FULL;
                end else begin
                    slot_values[(int'(head_slot) + held_count) % dqdel_pkg::DEPTH] = item;
                    held_count++;
                end
            end
            dqdel_pkg::KIND_INSERT: begin
                if (held_count >= dqdel_pkg::DEPTH) begin
                    res.status = dqdel_pkg::ST_FULL;
                end else begin
                    head_slot = dqdel_pkg::t_idx'((int'(head_slot) + dqdel_pkg::DEPTH - 1)
                                                  % dqdel_pkg::DEPTH);
                    slot_values[head_slot] = item;
                    held_count++;
                end
            end
            dqdel_pkg::KIND_POP: begin
                if (held_count == 0) begin
                    res.status = dqdel_pkg::ST_EMPTY;
                end else begin
                    res.popped = dqdel_pkg::VALUE_W'(slot_values[head_slot]);
                    head_slot  = dqdel_pkg::t_idx'((int'(head_slot) + 1) % dqdel_pkg::DEPTH);
                    held_count--;
                end
            end
            default: begin
                // First match from the head; later entries move up one slot
                for (int i = 0; i < held_count && hit < 0; i++) begin
                    if (slot_values[(int'(head_slot) + i) % dqdel_pkg::DEPTH] == item) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    res.status = dqdel_pkg::ST_NOT_FOUND;
                end else begin
                    for (int i = hit; i + 1 < held_count; i++) begin
                        slot_values[(int'(head_slot) + i) % dqdel_pkg::DEPTH] =
                            slot_values[(int'(head_slot) + i + 1) % dqdel_pkg::DEPTH];
                    end
                    held_count--;
                end
            end
        endcase
        res.length = dqdel_pkg::LENGTH_W'(held_count);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int beat,
                                   input logic [dqdel_pkg::VALUE_W-1:0] got,
                                   input logic [dqdel_pkg::VALUE_W-1:0] want);
        $display("ERROR beat %0d: %s got %h expected %h", beat, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_request(input logic [dqdel_pkg::KIND_W-1:0] kind,
                               input logic [dqdel_pkg::VALUE_W-1:0] value);
        t_deque_request req;
        req.kind  = kind;
        req.value = value;
        pending_requests.push_back(req);
    endtask

    // Driver: launches request beats, predicts each one at acceptance
    always @(posedge i_clk) begin
        logic           fire;
        logic           launch;
        t_idle_phase    next_phase;
        t_deque_request req;
        fire   = 1'b0;
        launch = 1'b0;
        req    = '0;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fire = i_in_valid && o_in_ready;
            if (fire) begin
                expected_results[accepted_beats] <= apply_request(i_kind, i_item_value);
                accepted_beats <= accepted_beats + 1;
            end
            if (!(i_in_valid && !fire) && pending_requests.size() > 0) begin
                next_phase = t_idle_phase'(launched_beats * 5 / total_requests);
                if (next_phase != drive_phase) begin
                    // Drain everything in flight before switching pattern
                    if (received_beats == accepted_beats + int'(fire)) begin
                        drive_phase <= next_phase;
                    end
                end else if (drive_phase == PH_SEND_IDLE) begin
                    launch = ($urandom_range(99) >= 84);
                end else if (drive_phase == PH_BOTH_IDLE) begin
                    launch = ($urandom_range(99) >= 25);
                end else begin
                    launch = 1'b1;
                end
            end
            if (launch) begin
                req = pending_requests.pop_front();
                launched_beats++;
                i_kind       <= req.kind;
                i_item_value <= req.value;
                i_in_valid   <= 1'b1;
            end else if (!(i_in_valid && !fire)) begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks result beats in order, drives receiver stalls
    always @(posedge i_clk) begin
        t_deque_result want;
        want = '0;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (received_beats >= accepted_beats) begin
                    report_mismatch("result with nothing expected", received_beats,
                                    o_popped_item, '0);
                end else begin
                    want = expected_results[received_beats];
                    if (o_status !== want.status) begin
                        report_mismatch("status", received_beats,
                                        dqdel_pkg::VALUE_W'(o_status),
                                        dqdel_pkg::VALUE_W'(want.status));
                    end
                    if (o_popped_item !== want.popped) begin
                        report_mismatch("popped_item", received_beats,
                                        o_popped_item, want.popped);
                    end
                    if (o_length !== want.length) begin
                        report_mismatch("length", received_beats,
                                        dqdel_pkg::VALUE_W'(o_length),
                                        dqdel_pkg::VALUE_W'(want.length));
                    end
                    received_beats <= received_beats + 1;
                end
            end
            case (drive_phase)
                PH_RECV_STALL: i_out_ready <= ($urandom_range(99) >= 84);
                PH_BOTH_IDLE:  i_out_ready <= ($urandom_range(99) >= 25);
                default:       i_out_ready <= 1'b1;
            endcase
        end
    end

    // Stimulus, reset and end of run
    initial begin
        logic [dqdel_pkg::VALUE_W-1:0] value_pool [6];
        logic [dqdel_pkg::KIND_W-1:0]  kind;
        logic [dqdel_pkg::VALUE_W-1:0] value;
        int                            made;
        int                            seg_len;
        int                            roll;
        bit                            fill_mode;
        value_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                       32'h8000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A};

        // Directed: empty cases, both ends, duplicates, middle delete
        add_request(dqdel_pkg::KIND_POP,    32'h0000_0000);
        add_request(dqdel_pkg::KIND_DELETE, 32'h0000_0000);
        add_request(dqdel_pkg::KIND_APPEND, 32'h0000_0000);
        add_request(dqdel_pkg::KIND_APPEND, 32'hFFFF_FFFF);
        add_request(dqdel_pkg::KIND_INSERT, 32'hA5A5_A5A5);
        add_request(dqdel_pkg::KIND_INSERT, 32'hFFFF_FFFF);
        add_request(dqdel_pkg::KIND_DELETE, 32'hFFFF_FFFF);
        add_request(dqdel_pkg::KIND_DELETE, 32'h1234_5678);
        add_request(dqdel_pkg::KIND_DELETE, 32'h0000_0000);
        add_request(dqdel_pkg::KIND_POP,    32'h0000_0000);
        // Fill to capacity from both ends, then overflow on each end
        for (int i = 0; i < 15; i++) begin
            add_request((i % 2) ? dqdel_pkg::KIND_INSERT : dqdel_pkg::KIND_APPEND,
                        32'h0000_0100 + i);
        end
        add_request(dqdel_pkg::KIND_APPEND, 32'hFFFF_FFFF);
        add_request(dqdel_pkg::KIND_INSERT, 32'h0000_0000);
        add_request(dqdel_pkg::KIND_DELETE, 32'h0000_0100);

        // Random: segments biased toward filling or draining
        made = 0;
        while (made < RANDOM_ITEMS) begin
            seg_len   = $urandom_range(40, 10);
            fill_mode = $urandom_range(1, 0);
            for (int j = 0; j < seg_len && made < RANDOM_ITEMS; j++) begin
                roll = $urandom_range(99);
                if (fill_mode) begin
                    kind = (roll < 40) ? dqdel_pkg::KIND_APPEND :
                           (roll < 70) ? dqdel_pkg::KIND_INSERT :
                           (roll < 85) ? dqdel_pkg::KIND_POP : dqdel_pkg::KIND_DELETE;
                end else begin
                    kind = (roll < 10) ? dqdel_pkg::KIND_APPEND :
                           (roll < 20) ? dqdel_pkg::KIND_INSERT :
                           (roll < 65) ? dqdel_pkg::KIND_POP : dqdel_pkg::KIND_DELETE;
                end
                // Mostly a small value pool so deletes find duplicates
                if ($urandom_range(99) < 70) begin
                    value = value_pool[$urandom_range(5)];
                end else begin
                    value = $urandom();
                end
                add_request(kind, value);
                made++;
            end
        end
        total_requests = pending_requests.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() > 0 || i_in_valid) @(posedge i_clk);
        while (received_beats != accepted_beats) @(posedge i_clk);
        repeat (dqdel_pkg::DEPTH + 8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/dqdel_pkg.sv
rtl/dqdel_ram.sv
rtl/deque_with_delete_by_value_unit.sv
bench/testbench.sv
